### src/gdss_pkg.sv
// shared types, constants and helper functions for the gesture dwell/swing sequencer
// no dependencies
package gdss_pkg;

   localparam int POS_W       = 16;
   localparam int WAVE_OFFSET = 410;
   localparam int DIFF_W      = 18;
   localparam int WIDE_W      = (POS_W + 1 > DIFF_W) ? POS_W + 1 : DIFF_W;
   localparam int DIFF_SAT    = 131072;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int LIM_W       = 15;
   localparam int T2_W        = 2 * LIM_W;
   localparam int T2X9_W      = T2_W + 4;
   localparam int DWELL_W     = 16;
   localparam int DWELL_CNT_W = 17;
   localparam int SWING_W     = 8;
   localparam int SWING_CNT_W = 9;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int IN_FIELDS_W  = 6 * POS_W;
   localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
   localparam int OUT_FIELDS_W = 4 + 3 * POS_W;
   localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

   localparam logic [LIM_W-1:0]   SHAKE_LIM_RST = LIM_W'(410);
   localparam logic [LIM_W-1:0]   WAVE_LIM_RST  = LIM_W'(410);
   localparam logic [DWELL_W-1:0] DWELL_LIM_RST = DWELL_W'(200);
   localparam logic [SWING_W-1:0] SWING_LIM_RST = SWING_W'(5);

   typedef enum logic [2:0] {
      REG_REF_X       = 3'd0,
      REG_REF_Y       = 3'd1,
      REG_REF_Z       = 3'd2,
      REG_SHAKE_LIM   = 3'd3,
      REG_WAVE_LIM    = 3'd4,
      REG_DWELL_LIM   = 3'd5,
      REG_SWING_LIM   = 3'd6,
      REG_REARM       = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SHAKE  = 3'd1,
      PH_LEFT   = 3'd2,
      PH_RIGHT  = 3'd3,
      PH_RETURN = 3'd4
   } phase_type;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type z;
      pos_type y;
      pos_type x;
   } vec_type;

   typedef struct packed {
      vec_type wave;
      vec_type shake;
   } hands_type;

   typedef struct packed {
      logic far;
      logic ret;
      logic lhit;
      logic rhit;
   } flags_type;

   typedef struct packed {
      pos_type                ref_x;
      pos_type                ref_y;
      pos_type                ref_z;
      pos_type                left_y;
      pos_type                right_y;
      logic [T2_W-1:0]        shake_t2;
      logic [T2X9_W-1:0]      shake_t2x9;
      logic [T2_W-1:0]        wave_t2;
      logic [DWELL_W-1:0]     dwell_limit;
      logic [SWING_W-1:0]     swing_limit;
      logic                   rearm_enable;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      wave_set_active;
      logic      goal_valid;
      pos_type   goal_x;
      pos_type   goal_y;
      pos_type   goal_z;
   } rsp_type;

   // reference y moved by the wave offset, saturated to the position range
   function automatic pos_type target_y(input pos_type ry, input logic up);
      logic signed [POS_W:0] w;
      pos_type               r;
      if (up) begin
         w = {ry[POS_W-1], ry} + (POS_W+1)'(WAVE_OFFSET);
      end else begin
         w = {ry[POS_W-1], ry} - (POS_W+1)'(WAVE_OFFSET);
      end
      if (w[POS_W] != w[POS_W-1]) begin
         r = w[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = w[POS_W-1:0];
      end
      return r;
   endfunction

   // absolute difference, saturated
   function automatic logic [DIFF_W-1:0] abs_diff_sat(input pos_type a, input pos_type b);
      logic signed [POS_W:0] d;
      logic [POS_W:0]        mag;
      logic [WIDE_W-1:0]     wide;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      mag = d[POS_W] ? $unsigned(-d) : $unsigned(d);
      wide = WIDE_W'(mag);
      if (wide > WIDE_W'(DIFF_SAT)) begin
         wide = WIDE_W'(DIFF_SAT);
      end
      return wide[DIFF_W-1:0];
   endfunction

endpackage

### src/gdss_csr.sv
// configuration registers with apb-style access and derived thresholds
// depends on gdss_pkg
module gdss_csr import gdss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   pos_type              ref_x_ff, ref_y_ff, ref_z_ff;
   logic [LIM_W-1:0]     shake_lim_ff, wave_lim_ff;
   logic [DWELL_W-1:0]   dwell_lim_ff;
   logic [SWING_W-1:0]   swing_lim_ff;
   logic                 rearm_ff;
   logic [T2_W-1:0]      shake_t2_ff, wave_t2_ff;
   logic [T2X9_W-1:0]    shake_t2x9_ff;
   pos_type              left_y_ff, right_y_ff;
   logic                 wr;
   csr_reg_type          idx;

   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff     <= '0;
         ref_y_ff     <= '0;
         ref_z_ff     <= '0;
         shake_lim_ff <= SHAKE_LIM_RST;
         wave_lim_ff  <= WAVE_LIM_RST;
         dwell_lim_ff <= DWELL_LIM_RST;
         swing_lim_ff <= SWING_LIM_RST;
         rearm_ff     <= 1'b1;
      end else if (wr) begin
         unique case (idx)
            REG_REF_X:     ref_x_ff     <= csr_pwdata[POS_W-1:0];
            REG_REF_Y:     ref_y_ff     <= csr_pwdata[POS_W-1:0];
            REG_REF_Z:     ref_z_ff     <= csr_pwdata[POS_W-1:0];
            REG_SHAKE_LIM: shake_lim_ff <= csr_pwdata[LIM_W-1:0];
            REG_WAVE_LIM:  wave_lim_ff  <= csr_pwdata[LIM_W-1:0];
            REG_DWELL_LIM: dwell_lim_ff <= csr_pwdata[DWELL_W-1:0];
            REG_SWING_LIM: swing_lim_ff <= csr_pwdata[SWING_W-1:0];
            REG_REARM:     rearm_ff     <= csr_pwdata[0];
         endcase
      end
   end

   // derived values, registered from the limit and reference registers; shake_t2x9 is registered from shake_t2
   always_ff @(posedge clock) begin
      shake_t2_ff   <= T2_W'(shake_lim_ff) * T2_W'(shake_lim_ff);
      wave_t2_ff    <= T2_W'(wave_lim_ff) * T2_W'(wave_lim_ff);
      shake_t2x9_ff <= (T2X9_W'(shake_t2_ff) << 3) + T2X9_W'(shake_t2_ff);
      left_y_ff     <= target_y(ref_y_ff, 1'b0);
      right_y_ff    <= target_y(ref_y_ff, 1'b1);
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_REF_X:     csr_prdata = CSR_DW'($unsigned(ref_x_ff));
         REG_REF_Y:     csr_prdata = CSR_DW'($unsigned(ref_y_ff));
         REG_REF_Z:     csr_prdata = CSR_DW'($unsigned(ref_z_ff));
         REG_SHAKE_LIM: csr_prdata = CSR_DW'(shake_lim_ff);
         REG_WAVE_LIM:  csr_prdata = CSR_DW'(wave_lim_ff);
         REG_DWELL_LIM: csr_prdata = CSR_DW'(dwell_lim_ff);
         REG_SWING_LIM: csr_prdata = CSR_DW'(swing_lim_ff);
         REG_REARM:     csr_prdata = CSR_DW'(rearm_ff);
      endcase
   end

   always_comb begin
      cfg.ref_x        = ref_x_ff;
      cfg.ref_y        = ref_y_ff;
      cfg.ref_z        = ref_z_ff;
      cfg.left_y       = left_y_ff;
      cfg.right_y      = right_y_ff;
      cfg.shake_t2     = shake_t2_ff;
      cfg.shake_t2x9   = shake_t2x9_ff;
      cfg.wave_t2      = wave_t2_ff;
      cfg.dwell_limit  = dwell_lim_ff;
      cfg.swing_limit  = swing_lim_ff;
      cfg.rearm_enable = rearm_ff;
   end

endmodule

### src/gdss_front.sv
// front end: input buffer, squared distances on one shared multiplier, threshold compares
// depends on gdss_pkg
module gdss_front import gdss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  hands_type req_hands,
   input  cfg_type   cfg,
   input  logic      q_full,
   output logic      push,
   output flags_type push_flags
);

   typedef enum logic [1:0] {
      DIST_SHAKE = 2'd0,
      DIST_LEFT  = 2'd1,
      DIST_RIGHT = 2'd2
   } dist_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      dist_type sel;
      logic     first;
      logic     last;
   } tag_type;

   logic               buf_vld_ff, buf_vld_in;
   hands_type          buf_ff;
   logic               run_ff, run_in;
   dist_type           dist_ff, dist_in;
   axis_type           axis_ff, axis_in;
   hands_type          work_ff;
   logic               s1_vld_ff;
   logic [DIFF_W-1:0]  s1_diff_ff;
   tag_type            s1_tag_ff, s1_tag_in;
   logic               s2_vld_ff;
   logic [SQ_W-1:0]    s2_sq_ff;
   tag_type            s2_tag_ff;
   logic [SUM_W-1:0]   acc_ff, sum;
   flags_type          flags_ff, flags_in;
   logic               pend_ff, pend_in;
   logic               accept, start, fin;
   vec_type            hand, tgt;
   pos_type            op_a, op_b;

   assign req_tready = !buf_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign push       = pend_ff && !q_full;
   assign push_flags = flags_ff;
   assign start      = !run_ff && buf_vld_ff && !s1_vld_ff && !s2_vld_ff && (!pend_ff || push);

   always_comb begin
      buf_vld_in = buf_vld_ff;
      if (accept) begin
         buf_vld_in = 1'b1;
      end else if (start) begin
         buf_vld_in = 1'b0;
      end
   end

   // step sequencing over distances and axes
   always_comb begin
      run_in  = run_ff;
      dist_in = dist_ff;
      axis_in = axis_ff;
      if (start) begin
         run_in  = 1'b1;
         dist_in = DIST_SHAKE;
         axis_in = AXIS_X;
      end else if (run_ff) begin
         priority if (axis_ff == AXIS_Z && dist_ff == DIST_RIGHT) begin
            run_in = 1'b0;
         end else if (axis_ff == AXIS_Z) begin
            axis_in = AXIS_X;
            dist_in = (dist_ff == DIST_SHAKE) ? DIST_LEFT : DIST_RIGHT;
         end else begin
            axis_in = (axis_ff == AXIS_X) ? AXIS_Y : AXIS_Z;
         end
      end
   end

   always_comb begin
      hand  = (dist_ff == DIST_SHAKE) ? work_ff.shake : work_ff.wave;
      tgt.x = cfg.ref_x;
      tgt.z = cfg.ref_z;
      unique case (dist_ff)
         DIST_SHAKE: tgt.y = cfg.ref_y;
         DIST_LEFT:  tgt.y = cfg.left_y;
         default:    tgt.y = cfg.right_y;
      endcase
      unique case (axis_ff)
         AXIS_X: begin
            op_a = hand.x;
            op_b = tgt.x;
         end
         AXIS_Y: begin
            op_a = hand.y;
            op_b = tgt.y;
         end
         default: begin
            op_a = hand.z;
            op_b = tgt.z;
         end
      endcase
      s1_tag_in.sel   = dist_ff;
      s1_tag_in.first = (axis_ff == AXIS_X);
      s1_tag_in.last  = (axis_ff == AXIS_Z);
   end

   // accumulate and compare
   assign fin = s2_vld_ff && s2_tag_ff.last;

   always_comb begin
      sum      = s2_tag_ff.first ? SUM_W'(s2_sq_ff) : acc_ff + SUM_W'(s2_sq_ff);
      flags_in = flags_ff;
      if (fin) begin
         unique case (s2_tag_ff.sel)
            DIST_SHAKE: begin
               flags_in.far = sum > SUM_W'(cfg.shake_t2);
               flags_in.ret = {sum, 4'b0000} < (SUM_W+4)'(cfg.shake_t2x9);
            end
            DIST_LEFT:  flags_in.lhit = sum < SUM_W'(cfg.wave_t2);
            default:    flags_in.rhit = sum < SUM_W'(cfg.wave_t2);
         endcase
      end
      pend_in = pend_ff;
      if (fin && s2_tag_ff.sel == DIST_RIGHT) begin
         pend_in = 1'b1;
      end else if (push) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         run_ff     <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         buf_vld_ff <= buf_vld_in;
         run_ff     <= run_in;
         s1_vld_ff  <= run_ff;
         s2_vld_ff  <= s1_vld_ff;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= req_hands;
      end
      if (start) begin
         work_ff <= buf_ff;
      end
      dist_ff    <= dist_in;
      axis_ff    <= axis_in;
      s1_diff_ff <= abs_diff_sat(op_a, op_b);
      s1_tag_ff  <= s1_tag_in;
      s2_sq_ff   <= SQ_W'(s1_diff_ff) * SQ_W'(s1_diff_ff);
      s2_tag_ff  <= s1_tag_ff;
      if (s2_vld_ff) begin
         acc_ff <= sum;
      end
      flags_ff   <= flags_in;
   end

   a_pend_after_last: assert property (@(posedge clock) disable iff (reset)
      fin && s2_tag_ff.sel == DIST_RIGHT |=> pend_ff)
      else $error("finished item not marked pending");

endmodule

### src/gdss_queue.sv
// short fifo of compare flags between front and back
// depends on gdss_pkg
module gdss_queue import gdss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  flags_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output logic      rd_vld,
   output flags_type rd_data
);

   flags_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_vld  = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_vld)
      else $error("read from empty queue");

endmodule

### src/gdss_back.sv
// back end: phase sequencer with dwell and swing counters, output register
// depends on gdss_pkg
module gdss_back import gdss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_vld,
   input  flags_type q_flags,
   output logic      pop,
   input  cfg_type   cfg,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output rsp_type   rsp
);

   phase_type              phase_ff, phase_in;
   logic [DWELL_CNT_W-1:0] dwell_ff, dwell_in, dwell_inc;
   logic [SWING_CNT_W-1:0] swing_ff, swing_in, swing_inc;
   logic                   out_vld_ff, out_vld_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   hit, goal, waving;

   assign pop        = q_vld && (!out_vld_ff || rsp_tready);
   assign rsp_tvalid = out_vld_ff;
   assign rsp        = rsp_ff;
   assign dwell_inc  = dwell_ff + 1'b1;
   assign swing_inc  = swing_ff + 1'b1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      dwell_in = dwell_ff;
      swing_in = swing_ff;
      hit      = (phase_ff == PH_LEFT) ? q_flags.lhit : q_flags.rhit;
      unique case (phase_ff)
         PH_START: begin
            if (q_flags.far) begin
               dwell_in = '0;
               phase_in = PH_SHAKE;
            end
         end
         PH_SHAKE: begin
            if (q_flags.far) begin
               dwell_in = '0;
            end else begin
               dwell_in = dwell_inc;
               if (dwell_inc > DWELL_CNT_W'(cfg.dwell_limit)) begin
                  swing_in = '0;
                  phase_in = PH_LEFT;
               end
            end
         end
         PH_LEFT, PH_RIGHT: begin
            if (hit) begin
               swing_in = swing_inc;
               if (swing_inc > SWING_CNT_W'(cfg.swing_limit)) begin
                  phase_in = PH_RETURN;
               end else begin
                  phase_in = (phase_ff == PH_LEFT) ? PH_RIGHT : PH_LEFT;
               end
            end
         end
         PH_RETURN: begin
            if (cfg.rearm_enable && q_flags.ret) begin
               phase_in = PH_START;
            end
         end
         default: phase_in = PH_START;
      endcase
   end

   // outputs
   always_comb begin
      waving                 = (phase_in == PH_LEFT) || (phase_in == PH_RIGHT);
      goal                   = waving && (phase_in != phase_ff);
      rsp_in.phase           = phase_in;
      rsp_in.wave_set_active = waving;
      rsp_in.goal_valid      = goal;
      rsp_in.goal_x          = goal ? cfg.ref_x : '0;
      rsp_in.goal_z          = goal ? cfg.ref_z : '0;
      rsp_in.goal_y          = '0;
      if (goal) begin
         rsp_in.goal_y = (phase_in == PH_LEFT) ? cfg.left_y : cfg.right_y;
      end
      out_vld_in = out_vld_ff;
      if (pop) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         dwell_ff   <= '0;
         swing_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (pop) begin
            phase_ff <= phase_in;
            dwell_ff <= dwell_in;
            swing_ff <= swing_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   a_goal_while_waving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.goal_valid |-> rsp.wave_set_active)
      else $error("goal issued outside wave phases");

   a_swing_cleared: assert property (@(posedge clock) disable iff (reset)
      pop && phase_ff == PH_SHAKE && phase_in == PH_LEFT |=> swing_ff == '0)
      else $error("swing count not cleared entering wave");

endmodule

### src/gesture_dwell_swing_sequencer_core.sv
// gesture sequencer top level: stream ports, configuration port, front/queue/back
// depends on gdss_pkg, gdss_csr, gdss_front, gdss_queue, gdss_back
// each item takes nine squarings on the shared front multiplier
// a second item is buffered while the first is at work; up to four results queue before back
// reset: synchronous, active high; phase returns to start, counters and queue clear,
// registers return to their defaults
module gesture_dwell_swing_sequencer_core import gdss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // shake_hand_x, shake_hand_y, shake_hand_z, wave_hand_x, wave_hand_y, wave_hand_z
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // phase, wave_set_active, goal_x, goal_y, goal_z, zero pad
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // goal_valid
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   cfg_type   cfg;
   hands_type req_hands;
   logic      push, q_full, pop, q_vld;
   flags_type push_flags, q_flags;
   rsp_type   rsp;

   assign req_hands.shake.x = req_tdata[0*POS_W +: POS_W];
   assign req_hands.shake.y = req_tdata[1*POS_W +: POS_W];
   assign req_hands.shake.z = req_tdata[2*POS_W +: POS_W];
   assign req_hands.wave.x  = req_tdata[3*POS_W +: POS_W];
   assign req_hands.wave.y  = req_tdata[4*POS_W +: POS_W];
   assign req_hands.wave.z  = req_tdata[5*POS_W +: POS_W];

   assign rsp_tdata = OUT_DATA_W'({rsp.goal_z, rsp.goal_y, rsp.goal_x,
                                   rsp.wave_set_active, rsp.phase});
   assign rsp_tuser = rsp.goal_valid;

   gdss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gdss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_hands  (req_hands),
      .cfg        (cfg),
      .q_full     (q_full),
      .push       (push),
      .push_flags (push_flags)
   );

   gdss_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_flags),
      .full    (q_full),
      .rd_en   (pop),
      .rd_vld  (q_vld),
      .rd_data (q_flags)
   );

   gdss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_vld      (q_vld),
      .q_flags    (q_flags),
      .pop        (pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

endmodule

### verif/gdss_checker.sv
`timescale 1ns / 100ps
// checker for the gesture dwell/swing sequencer: follows register writes, predicts
// one result per input transfer and compares each result transfer field by field
// depends on gdss_pkg
module gdss_checker import gdss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    errors
);

   typedef struct {
      logic [2:0] phase;
      logic       wave_active;
      logic       goal_valid;
      pos_type    goal_x;
      pos_type    goal_y;
      pos_type    goal_z;
   } tick_result_type;

   tick_result_type due_q[$];

   phase_type                seq_phase;
   logic [DWELL_CNT_W-1:0]   dwell_cnt;
   logic [SWING_CNT_W-1:0]   swing_cnt;

   pos_type                  cfg_ref_x, cfg_ref_y, cfg_ref_z;
   logic [LIM_W-1:0]         cfg_shake_lim, cfg_wave_lim;
   logic [DWELL_W-1:0]       cfg_dwell_lim;
   logic [SWING_W-1:0]       cfg_swing_lim;
   logic                     cfg_rearm;

   function automatic longint gap(longint a, longint b);
      longint d;
      d = (a >= b) ? a - b : b - a;
      return (d > DIFF_SAT) ? DIFF_SAT : d;
   endfunction

   function automatic longint span2(vec_type p, longint cx, longint cy, longint cz);
      longint dx, dy, dz;
      dx = gap(p.x, cx);
      dy = gap(p.y, cy);
      dz = gap(p.z, cz);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   function automatic pos_type shifted_y(pos_type ry, longint delta);
      longint v;
      v = ry + delta;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return pos_type'(v);
   endfunction

   task automatic predict_tick(hands_type h);
      longint          sh_d2, lf_d2, rt_d2, sh_t2, wv_t2;
      pos_type         left_y, right_y, gy;
      logic            goal;
      tick_result_type r;
      left_y  = shifted_y(cfg_ref_y, -WAVE_OFFSET);
      right_y = shifted_y(cfg_ref_y, WAVE_OFFSET);
      sh_d2 = span2(h.shake, cfg_ref_x, cfg_ref_y, cfg_ref_z);
      lf_d2 = span2(h.wave, cfg_ref_x, left_y, cfg_ref_z);
      rt_d2 = span2(h.wave, cfg_ref_x, right_y, cfg_ref_z);
      sh_t2 = longint'(cfg_shake_lim) * longint'(cfg_shake_lim);
      wv_t2 = longint'(cfg_wave_lim) * longint'(cfg_wave_lim);
      goal = 1'b0;
      gy = '0;
      case (seq_phase)
         PH_START: begin
            if (sh_d2 > sh_t2) begin
               dwell_cnt = '0;
               seq_phase = PH_SHAKE;
            end
         end
         PH_SHAKE: begin
            if (sh_d2 > sh_t2) begin
               dwell_cnt = '0;
            end else begin
               dwell_cnt = dwell_cnt + 1'b1;
               if (dwell_cnt > cfg_dwell_lim) begin
                  goal = 1'b1;
                  gy = left_y;
                  swing_cnt = '0;
                  seq_phase = PH_LEFT;
               end
            end
         end
         PH_LEFT, PH_RIGHT: begin
            if (((seq_phase == PH_LEFT) ? lf_d2 : rt_d2) < wv_t2) begin
               swing_cnt = swing_cnt + 1'b1;
               if (swing_cnt > cfg_swing_lim) begin
                  seq_phase = PH_RETURN;
               end else if (seq_phase == PH_LEFT) begin
                  goal = 1'b1;
                  gy = right_y;
                  seq_phase = PH_RIGHT;
               end else begin
                  goal = 1'b1;
                  gy = left_y;
                  seq_phase = PH_LEFT;
               end
            end
         end
         PH_RETURN: begin
            if (cfg_rearm && 16 * sh_d2 < 9 * sh_t2) seq_phase = PH_START;
         end
         default: seq_phase = PH_START;
      endcase
      r.phase       = seq_phase;
      r.wave_active = (seq_phase == PH_LEFT || seq_phase == PH_RIGHT);
      r.goal_valid  = goal;
      r.goal_x      = goal ? cfg_ref_x : '0;
      r.goal_y      = goal ? gy : '0;
      r.goal_z      = goal ? cfg_ref_z : '0;
      due_q = {due_q, r};
   endtask

   task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      tick_result_type want;
      if (due_q.size() == 0) begin
         errors++;
         $display("%0t ns: result transfer with nothing expected, got %h/%b",
                  $time, rsp_tdata, rsp_tuser);
      end else begin
         want = due_q.pop_front();
         check_field("phase", want.phase, rsp_tdata[2:0]);
         check_field("wave_set_active", want.wave_active, rsp_tdata[3]);
         check_field("goal_valid", want.goal_valid, rsp_tuser);
         check_field("goal_x", want.goal_x, rsp_tdata[4 +: POS_W]);
         check_field("goal_y", want.goal_y, rsp_tdata[4 + POS_W +: POS_W]);
         check_field("goal_z", want.goal_z, rsp_tdata[4 + 2 * POS_W +: POS_W]);
         check_field("pad", '0, rsp_tdata[OUT_DATA_W-1:4 + 3 * POS_W]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seq_phase = PH_START;
         dwell_cnt = '0;
         swing_cnt = '0;
         cfg_ref_x = '0;
         cfg_ref_y = '0;
         cfg_ref_z = '0;
         cfg_shake_lim = SHAKE_LIM_RST;
         cfg_wave_lim = WAVE_LIM_RST;
         cfg_dwell_lim = DWELL_LIM_RST;
         cfg_swing_lim = SWING_LIM_RST;
         cfg_rearm = 1'b1;
         due_q.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[CSR_AW-1:2]))
               REG_REF_X:     cfg_ref_x = csr_pwdata[POS_W-1:0];
               REG_REF_Y:     cfg_ref_y = csr_pwdata[POS_W-1:0];
               REG_REF_Z:     cfg_ref_z = csr_pwdata[POS_W-1:0];
               REG_SHAKE_LIM: cfg_shake_lim = csr_pwdata[LIM_W-1:0];
               REG_WAVE_LIM:  cfg_wave_lim = csr_pwdata[LIM_W-1:0];
               REG_DWELL_LIM: cfg_dwell_lim = csr_pwdata[DWELL_W-1:0];
               REG_SWING_LIM: cfg_swing_lim = csr_pwdata[SWING_W-1:0];
               REG_REARM:     cfg_rearm = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_tick(hands_type'(req_tdata[IN_FIELDS_W-1:0]));
      end
      pending = due_q.size();
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// testbench top for gesture_dwell_swing_sequencer_core: drives gesture streams and
// register settings, varies idling on both channels; depends on gdss_pkg and gdss_checker
module tb_top import gdss_pkg::*; ;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 150;
   localparam int STG_AWAY  = 0;
   localparam int STG_DWELL = 1;
   localparam int STG_WAVE  = 2;
   localparam int STG_BACK  = 3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // shake x, y, z, wave x, y, z
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // phase, wave_set_active, goal_x, goal_y, goal_z, zero pad
   logic [OUT_DATA_W-1:0] rsp_tdata;
   // goal_valid
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   int pending, errors;
   int send_idle = 22;
   int recv_idle = 56;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_cycles = 0;

   int cfg_rx, cfg_ry, cfg_rz, cfg_shake, cfg_wave, cfg_dwell, cfg_swing, cfg_rearm;

   always #1 clock = ~clock;

   gesture_dwell_swing_sequencer_core dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   gdss_checker u_chk (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .pending, .errors
   );

   // receiver side: random backpressure plus an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic pos_type clamp_pos(int v);
      if (v > 32767) return pos_type'(32767);
      if (v < -32768) return pos_type'(-32768);
      return pos_type'(v);
   endfunction

   function automatic pos_type jitter(int c, int span);
      return clamp_pos(c + int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic vec_type pt(int x, int y, int z);
      return '{x: clamp_pos(x), y: clamp_pos(y), z: clamp_pos(z)};
   endfunction

   function automatic vec_type near_pt(int cx, int cy, int cz, int span);
      return '{x: jitter(cx, span), y: jitter(cy, span), z: jitter(cz, span)};
   endfunction

   // moved along x just past the limit, away from the nearer range end
   function automatic vec_type far_pt(int cx, int cy, int cz, int lim);
      int x;
      x = (cx >= 0) ? cx - lim - 1 - int'($urandom_range(500))
                    : cx + lim + 1 + int'($urandom_range(500));
      return '{x: clamp_pos(x), y: jitter(cy, 200), z: jitter(cz, 200)};
   endfunction

   function automatic vec_type any_pt();
      return vec_type'({$urandom, $urandom});
   endfunction

   function automatic pos_type rnd_pos();
      return pos_type'($urandom);
   endfunction

   function automatic hands_type pair(vec_type s, vec_type w);
      return '{wave: w, shake: s};
   endfunction

   task automatic send_item(hands_type h);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= IN_DATA_W'(h);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_write(csr_reg_type r, logic [CSR_DW-1:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_setting(int rx, int ry, int rz, int shake, int wave,
                               int dwell, int swing, int rearm);
      cfg_rx = rx; cfg_ry = ry; cfg_rz = rz;
      cfg_shake = shake; cfg_wave = wave;
      cfg_dwell = dwell; cfg_swing = swing; cfg_rearm = rearm;
      csr_write(REG_REF_X, rx);
      csr_write(REG_REF_Y, ry);
      csr_write(REG_REF_Z, rz);
      csr_write(REG_SHAKE_LIM, shake);
      csr_write(REG_WAVE_LIM, wave);
      csr_write(REG_DWELL_LIM, dwell);
      csr_write(REG_SWING_LIM, swing);
      csr_write(REG_REARM, rearm);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // gesture sequences with random content: away, dwell near, alternate waves, come back
   task automatic run_gestures(int count);
      int      stage, held, hits;
      logic    on_left;
      int      ty;
      vec_type s, w;
      stage = STG_AWAY;
      held = 0;
      hits = 0;
      on_left = 1'b1;
      repeat (count) begin
         s = any_pt();
         w = any_pt();
         if ($urandom_range(99) >= 12) begin
            case (stage)
               STG_AWAY: begin
                  s = far_pt(cfg_rx, cfg_ry, cfg_rz, cfg_shake);
                  stage = STG_DWELL;
                  held = 0;
               end
               STG_DWELL: begin
                  s = near_pt(cfg_rx, cfg_ry, cfg_rz, cfg_shake / 3);
                  held++;
                  if (held > cfg_dwell) begin
                     stage = STG_WAVE;
                     hits = 0;
                     on_left = 1'b1;
                  end
               end
               STG_WAVE: begin
                  s = near_pt(cfg_rx, cfg_ry, cfg_rz, cfg_shake / 3);
                  if ($urandom_range(9) != 0) begin
                     ty = on_left ? clamp_pos(cfg_ry - WAVE_OFFSET)
                                  : clamp_pos(cfg_ry + WAVE_OFFSET);
                     w = near_pt(cfg_rx, ty, cfg_rz, cfg_wave / 3);
                     hits++;
                     on_left = !on_left;
                     if (hits > cfg_swing) stage = STG_BACK;
                  end
               end
               default: begin
                  s = near_pt(cfg_rx, cfg_ry, cfg_rz, cfg_shake / 3);
                  if (cfg_rearm != 0) stage = STG_AWAY;
               end
            endcase
         end else if (stage == STG_DWELL) begin
            held = 0;
         end
         send_item(pair(s, w));
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      vec_type zero_pt;
      zero_pt = pt(0, 0, 0);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: boundaries and extreme coordinates
      cfg_rx = 0; cfg_ry = 0; cfg_rz = 0; cfg_shake = 410; cfg_wave = 410;
      cfg_dwell = 200; cfg_swing = 5; cfg_rearm = 1;
      send_item(pair(zero_pt, zero_pt));
      send_item(pair(pt(410, 0, 0), zero_pt));
      send_item(pair(pt(411, 0, 0), zero_pt));
      send_item(pair(pt(5, -3, 7), zero_pt));
      send_item(pair(pt(32767, 32767, 32767), pt(32767, 32767, 32767)));
      send_item(pair(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768)));
      send_item(pair(pt(-32768, 32767, -32768), pt(32767, -32768, 32767)));
      send_item(pair(pt(-1, -1, -1), pt(-1, 0, -1)));
      settle();

      // short gesture, right goal saturating high, rearm off then on
      load_setting(-32768, 32667, 32767, 410, 410, 1, 1, 0);
      send_item(pair(pt(-32768 + 411, 32667, 32767), zero_pt));
      send_item(pair(pt(-32768, 32667, 32767), zero_pt));
      send_item(pair(pt(-32768, 32667, 32767), zero_pt));
      send_item(pair(pt(-32768, 32667, 32767), pt(-32768 + 410, 32257, 32767)));
      send_item(pair(pt(-32768, 32667, 32767), pt(-32768, 32257, 32767)));
      send_item(pair(pt(-32768, 32667, 32767), pt(-32768, 32767, 32767)));
      send_item(pair(pt(-32768, 32667, 32767), zero_pt));
      settle();
      cfg_rearm = 1;
      csr_write(REG_REARM, 1);
      send_item(pair(pt(-32768 + 308, 32667, 32767), zero_pt));
      send_item(pair(pt(-32768 + 307, 32667, 32767), zero_pt));
      settle();

      load_setting(0, 0, 0, 410, 410, 3, 5, 1);
      hold_token <= hold_token + 1;
      run_gestures(200);
      settle();
      load_setting(32767, 32767, -32768, 32767, 32767, 0, 0, 1);
      run_gestures(120);
      settle();
      load_setting(-32768, -32768, 32767, 1, 1, 2, 2, 1);
      run_gestures(120);
      settle();

      send_idle = 56;
      recv_idle = 22;
      load_setting(rnd_pos(), rnd_pos(), rnd_pos(), 0, 0, 65535, 255, 0);
      run_gestures(60);
      settle();
      load_setting(rnd_pos(), rnd_pos(), rnd_pos(), 2000, 300, 1, 255, 1);
      hold_token <= hold_token + 1;
      run_gestures(300);
      settle();

      send_idle = 0;
      recv_idle = 0;
      load_setting(rnd_pos(), rnd_pos(), rnd_pos(), 500, 500, 4, 3, 0);
      run_gestures(100);
      settle();
      load_setting(rnd_pos(), rnd_pos(), rnd_pos(), 300 + $urandom_range(3000),
                   200 + $urandom_range(2000), 200, 5, 1);
      run_gestures(260);
      settle();

      if (errors == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
src/gdss_pkg.sv
src/gdss_csr.sv
src/gdss_front.sv
src/gdss_queue.sv
src/gdss_back.sv
src/gesture_dwell_swing_sequencer_core.sv
verif/gdss_checker.sv
verif/tb_top.sv
